// File: src/sum_checked_frame_receiver_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the checksummed frame receiver
// Concurrent checks with an enable switch; empty when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SUM_CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset
`define SCFR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scfr assertion failed");

// Checked on every edge, reset included
`define SCFR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("scfr assertion failed");

`else

`define SCFR_ASSERT(label, prop)
`define SCFR_ASSERT_ALWAYS(label, prop)

`endif

`endif

// File: src/scfr_pkg.sv
// ---------------------------------------------------------------------------
// scfr_pkg
// Types and constants of the checksummed frame receiver.
// ---------------------------------------------------------------------------
package scfr_pkg;

    // Header byte after reset
    localparam logic [7:0] HEADER_RESET = 8'hAA;

    // Receive phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    // One result item
    typedef struct packed {
        logic       is_frame_end;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic       checksum_ok;
    } result_t;

endpackage

// File: src/sum_checked_frame_receiver_core.sv
// ---------------------------------------------------------------------------
// sum_checked_frame_receiver_core
// Header / length / payload / 8-bit sum deframer with streaming output.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, rx_byte) takes one received byte per
//   transfer. The block hunts for a byte equal to header_value, then takes
//   a length byte, that many payload bytes and a checksum byte.
//   Output channel (out_valid, out_stall, result fields) gives one transfer
//   per payload byte (with its index and the frame length) and one
//   end-of-frame transfer carrying the length and a checksum match flag.
//   Header, length and hunted bytes give no output.
//   A result is registered in the result register, or in the skid entry.
//   Throughput: one byte per cycle while in_stall is low; the per-byte state
//   update and the result register sit behind one short add and compare.
//   A two-entry output stage (result register plus skid register) lets the
//   block keep taking bytes while a result waits; in_stall rises only when
//   both entries are full, and is a register output.
//   Reset: hunting, empty output stage, header_value = 0xAA.
//   cfg_we/cfg_data write header_value; write only while idle.
// ---------------------------------------------------------------------------
`include "sum_checked_frame_receiver_core_defines.svh"

module sum_checked_frame_receiver_core (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_frame_end,
    output logic [7:0] payload_byte,
    output logic [7:0] byte_index,
    output logic [7:0] frame_length,
    output logic       checksum_ok
);

    logic [7:0]        header_value_reg;
    scfr_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        payload_count_reg, payload_count_next;
    logic [7:0]        announced_length_reg, announced_length_next;
    logic [7:0]        running_sum_reg, running_sum_next;

    logic              out_valid_reg, out_valid_next;
    scfr_pkg::result_t out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    scfr_pkg::result_t skid_data_reg, skid_data_next;

    logic              accept;
    logic              pop;
    logic              res_valid;
    scfr_pkg::result_t res;
    logic [7:0]        count_inc;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid_reg && !out_stall;
    assign count_inc = payload_count_reg + 8'd1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg <= scfr_pkg::HEADER_RESET;
        end
        else if (cfg_we)
        begin
            header_value_reg <= cfg_data;
        end
    end

    // Frame state update and result for the byte on the input
    always_comb
    begin
        phase_next            = phase_reg;
        payload_count_next    = payload_count_reg;
        announced_length_next = announced_length_reg;
        running_sum_next      = running_sum_reg;
        res_valid             = 1'b0;
        res                   = '0;
        case (phase_reg)
            scfr_pkg::PH_HUNT:
            begin
                if (rx_byte == header_value_reg)
                begin
                    phase_next = scfr_pkg::PH_LEN;
                end
            end
            scfr_pkg::PH_LEN:
            begin
                announced_length_next = rx_byte;
                payload_count_next    = 8'd0;
                running_sum_next      = 8'd0;
                phase_next = (rx_byte == 8'd0) ? scfr_pkg::PH_SUM : scfr_pkg::PH_DATA;
            end
            scfr_pkg::PH_DATA:
            begin
                res_valid          = 1'b1;
                res.is_frame_end   = 1'b0;
                res.payload_byte   = rx_byte;
                res.byte_index     = payload_count_reg;
                res.frame_length   = announced_length_reg;
                res.checksum_ok    = 1'b0;
                running_sum_next   = running_sum_reg + rx_byte;
                payload_count_next = count_inc;
                if (count_inc == announced_length_reg)
                begin
                    phase_next = scfr_pkg::PH_SUM;
                end
            end
            scfr_pkg::PH_SUM:
            begin
                res_valid          = 1'b1;
                res.is_frame_end   = 1'b1;
                res.frame_length   = announced_length_reg;
                res.checksum_ok    = (running_sum_reg == rx_byte);
                phase_next         = scfr_pkg::PH_HUNT;
                payload_count_next = 8'd0;
                running_sum_next   = 8'd0;
            end
            default:
            begin
                phase_next = scfr_pkg::PH_HUNT;
            end
        endcase
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= scfr_pkg::PH_HUNT;
            payload_count_reg    <= 8'd0;
            announced_length_reg <= 8'd0;
            running_sum_reg      <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg            <= phase_next;
            payload_count_reg    <= payload_count_next;
            announced_length_reg <= announced_length_next;
            running_sum_reg      <= running_sum_next;
        end
    end

    // Output stage: result register with a skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                // no accept can happen while the skid entry is full
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept && res_valid;
                out_data_next  = res;
            end
        end
        else if (accept && res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload of the output stage, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign is_frame_end = out_data_reg.is_frame_end;
    assign payload_byte = out_data_reg.payload_byte;
    assign byte_index   = out_data_reg.byte_index;
    assign frame_length = out_data_reg.frame_length;
    assign checksum_ok  = out_data_reg.checksum_ok;

    // Checks
    `SCFR_ASSERT_ALWAYS(a_skid_behind_out, (skid_valid_reg |-> out_valid_reg))
    `SCFR_ASSERT(a_data_count_in_range,
        ((phase_reg == scfr_pkg::PH_DATA) |-> (payload_count_reg < announced_length_reg)))
    `SCFR_ASSERT(a_payload_index_in_range,
        ((out_valid_reg && !out_data_reg.is_frame_end) |->
            (out_data_reg.byte_index < out_data_reg.frame_length)))
    `SCFR_ASSERT(a_frame_end_fields_zero,
        ((out_valid_reg && out_data_reg.is_frame_end) |->
            (out_data_reg.payload_byte == 8'd0 && out_data_reg.byte_index == 8'd0)))
    `SCFR_ASSERT(a_drain_empties,
        ((pop && !skid_valid_reg && !(accept && res_valid)) |=> !out_valid_reg))

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checksummed frame receiver. A short table of
// hand-written bytes (zero length, bad and good checksums, header bytes
// inside a frame) is followed by random frames under three header values.
// Each accepted byte runs through a local deframer model. Each output
// transfer is compared field by field with the oldest expected result.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LATENCY        = 1;
    localparam int PHASE_ITEMS    = 300;
    localparam int DIRECTED_ROWS  = 24;

    // One directed row: byte to send, typed-result flag, typed result
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic       is_end;
        logic [7:0] data;
        logic [7:0] idx;
        logic [7:0] len;
        logic       ok;
    } stim_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       is_frame_end;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic       checksum_ok;

    // Typed expectation travels with the byte it belongs to
    logic                typed_check  = 1'b0;
    scfr_pkg::result_t   typed_result = '0;

    // Deframer model state
    scfr_pkg::phase_t    rx_phase;
    logic [7:0]          header_model;
    logic [7:0]          rx_count;
    logic [7:0]          rx_length;
    logic [7:0]          rx_sum;

    scfr_pkg::result_t   expected_results[$];
    int         error_count  = 0;
    int         stuck_cycles = 0;
    int         sent_items   = 0;
    int         send_idle_pct = 12;
    int         recv_idle_pct = 68;
    logic [7:0] header_now   = scfr_pkg::HEADER_RESET;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // hunting: neither byte is the header
        {8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        // zero length, checksum 0 matches
        {8'hAA, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h00, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1},
        // zero length, checksum mismatch
        {8'hAA, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h01, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0},
        // three bytes, header value as payload, sum wraps to 0xAB
        {8'hAA, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h03, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'hFF, 1'b1, 1'b0, 8'hFF, 8'h00, 8'h03, 1'b0},
        {8'hAA, 1'b1, 1'b0, 8'hAA, 8'h01, 8'h03, 1'b0},
        {8'h02, 1'b1, 1'b0, 8'h02, 8'h02, 8'h03, 1'b0},
        {8'hAB, 1'b1, 1'b1, 8'h00, 8'h00, 8'h03, 1'b1},
        // header value as payload and as checksum
        {8'hAA, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'hAA, 1'b1, 1'b0, 8'hAA, 8'h00, 8'h01, 1'b0},
        {8'hAA, 1'b1, 1'b1, 8'h00, 8'h00, 8'h01, 1'b1},
        // two bytes, wrong checksum
        {8'hAA, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h02, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h80, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h7F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        {8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
        // back to hunting
        {8'h55, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0}
    };

    sum_checked_frame_receiver_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_frame_end (is_frame_end),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .checksum_ok  (checksum_ok)
    );

    always #10 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Advance the deframer by one byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b,
                                        output scfr_pkg::result_t r);
        r = '0;
        case (rx_phase)
            scfr_pkg::PH_HUNT:
            begin
                if (b == header_model)
                    rx_phase = scfr_pkg::PH_LEN;
                return 1'b0;
            end
            scfr_pkg::PH_LEN:
            begin
                rx_length = b;
                rx_count  = 8'h00;
                rx_sum    = 8'h00;
                rx_phase  = (b == 8'h00) ? scfr_pkg::PH_SUM : scfr_pkg::PH_DATA;
                return 1'b0;
            end
            scfr_pkg::PH_DATA:
            begin
                r.payload_byte = b;
                r.byte_index   = rx_count;
                r.frame_length = rx_length;
                rx_sum   = rx_sum + b;
                rx_count = rx_count + 8'h01;
                if (rx_count == rx_length)
                    rx_phase = scfr_pkg::PH_SUM;
                return 1'b1;
            end
            default:
            begin
                r.is_frame_end = 1'b1;
                r.frame_length = rx_length;
                r.checksum_ok  = (rx_sum == b);
                rx_phase = scfr_pkg::PH_HUNT;
                rx_count = 8'h00;
                rx_sum   = 8'h00;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
            error_count++;
        end
    endfunction

    // Scoreboard: check output transfers, then predict from input transfers
    always @(posedge clk)
    begin : scoreboard
        scfr_pkg::result_t seen;
        scfr_pkg::result_t want;
        scfr_pkg::result_t next;
        bit      produced;
        bit      moved;
        if (!rst_n)
        begin
            rx_phase     = scfr_pkg::PH_HUNT;
            header_model = scfr_pkg::HEADER_RESET;
            rx_count     = 8'h00;
            rx_length    = 8'h00;
            rx_sum       = 8'h00;
            stuck_cycles = 0;
        end
        else
        begin
            moved = cfg_we;
            if (cfg_we)
                header_model = cfg_data;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                seen  = {is_frame_end, payload_byte, byte_index, frame_length, checksum_ok};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result expected none actual %h", $time, seen);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("is_frame_end", 8'(want.is_frame_end),
                                8'(seen.is_frame_end));
                    check_field("payload_byte", want.payload_byte, seen.payload_byte);
                    check_field("byte_index", want.byte_index, seen.byte_index);
                    check_field("frame_length", want.frame_length, seen.frame_length);
                    check_field("checksum_ok", 8'(want.checksum_ok),
                                8'(seen.checksum_ok));
                end
            end
            if (in_valid && !in_stall)
            begin
                moved    = 1'b1;
                produced = deframe_byte(rx_byte, next);
                if (typed_check)
                    expected_results.push_back(typed_result);
                else if (produced)
                    expected_results.push_back(next);
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
        end
    end

    // Watchdog
    initial
    begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // One byte transfer, after a random sender gap
    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input scfr_pkg::result_t want = '0);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        rx_byte      <= b;
        typed_check  <= typed;
        typed_result <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold the sender until every expected result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2)
            @(posedge clk);
    endtask

    task automatic write_header(input logic [7:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        header_now = value;
    endtask

    // Header, length, payload, checksum; sometimes noise ahead, a bad sum,
    // or a frame cut short so the block reads on into the next one
    task automatic send_frame(input int unsigned len);
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned stop_at;
        sum     = 8'h00;
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len + 1;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == header_now);
                send_byte(b);
            end
        end
        send_byte(header_now);
        send_byte(8'(len));
        sent_items += 2;
        for (int unsigned k = 0; k < len; k++)
        begin
            if (k == stop_at)
                return;
            b = 8'($urandom_range(0, 255));
            sum += b;
            send_byte(b);
            sent_items++;
            if ($urandom_range(0, 299) == 0)
                wait_drained();
        end
        if (stop_at == len)
            return;
        send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : sum);
        sent_items++;
    endtask

    // Main sequence
    initial
    begin
        scfr_pkg::result_t want;
        int unsigned       len;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset header value
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            want = {directed_rows[i].is_end, directed_rows[i].data, directed_rows[i].idx,
                    directed_rows[i].len, directed_rows[i].ok};
            send_byte(directed_rows[i].rx, directed_rows[i].typed, want);
        end

        // random frames: one header setting and one idle pattern per phase
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 68;
                    write_header(8'h00);
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 12;
                    write_header(8'hFF);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_header(8'($urandom_range(0, 255)));
                end
            endcase
            sent_items = 0;
            // longest frame once, to reach the last byte index
            if (ph == 0)
                send_frame(255);
            while (sent_items < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 255)
                                                   : $urandom_range(0, 8);
                send_frame(len);
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/scfr_pkg.sv
src/sum_checked_frame_receiver_core.sv
tb/sv/tb_top.sv
